### rtl/rlie_pkg.sv
// ----------------------------------------------------------------------------
// rlie_pkg: shared types and constants of the load-immediate expander
// Word layouts on both queue sides, instruction codes and the plan record
// that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package rlie_pkg;

  // Peeled chunks per constant; a 64-bit value never needs more than three.
  localparam int unsigned MaxChunks        = 3;
  localparam int unsigned ChunkCntW        = $clog2(MaxChunks + 1);
  localparam int unsigned PlanDepthDefault = 2;

  localparam logic [63:0] TopMask   = 64'hFFFF_FFFF_FFFF_F800;
  localparam logic [63:0] RoundAdd  = 64'h800;
  localparam logic [31:0] RoundAddW = 32'h800;
  localparam logic [5:0]  ChunkBase = 6'd12;

  typedef enum logic [2:0] {
    OP_LUI   = 3'd0,
    OP_ADDI  = 3'd1,
    OP_ADDIW = 3'd2,
    OP_SLLI  = 3'd3,
    OP_SRLI  = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [63:0] load_value;
    logic [4:0]  dest_reg;
    logic        narrow_register;
  } in_item_t;

  typedef struct packed {
    opcode_e     opcode;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [19:0] immediate;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [4:0]                  rd;
    logic [19:0]                 lui_imm;
    logic                        add_en;
    opcode_e                     add_op;
    logic [11:0]                 add_imm;
    logic [ChunkCntW-1:0]        nchunks;
    logic [MaxChunks-1:0][11:0]  chunk_imm;
    logic [MaxChunks-1:0][5:0]   chunk_shift;
    logic                        tail_en;
    logic [5:0]                  tail_amt;
  } plan_t;

endpackage

### rtl/rlie_front.sv
// ----------------------------------------------------------------------------
// rlie_front: accept a constant and turn it into an instruction plan
// Classifies the word, peels 12-bit chunks off the constant (for each chunk:
// round, then strip trailing zeros) and pushes one plan record.
// ----------------------------------------------------------------------------
module rlie_front import rlie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_push_i,
  output logic     in_full_o,
  input  in_item_t in_data_i,
  output logic     plan_push_o,
  input  logic     plan_full_i,
  output plan_t    plan_o
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_LOOP,
    F_NORM,
    F_FINAL
  } state_e;

  state_e                     state_q, state_d;
  logic [63:0]                val_q;
  logic [63:0]                rest_q;
  logic [4:0]                 rd_q;
  logic                       narrow_q;
  logic [51:0]                upper_q;
  logic [ChunkCntW-1:0]       nch_q;
  logic [MaxChunks-1:0][11:0] chunk_imm_q;
  logic [MaxChunks-1:0][5:0]  chunk_shift_q;

  logic        accept;
  logic [63:0] round_sum;
  logic [5:0]  lsb;
  logic [51:0] shifted;
  logic        top_ones;
  logic        more;
  logic [31:0] word;
  logic [31:0] word_sum;
  logic [5:0]  val_msb;

  function automatic logic [5:0] low_one(input logic [51:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 51; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  function automatic logic [5:0] high_one(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  assign accept    = in_push_i && !in_full_o;
  assign in_full_o = (state_q != F_IDLE);

  assign round_sum = rest_q + RoundAdd;
  assign lsb       = low_one(upper_q);
  assign shifted   = upper_q >> lsb;
  assign top_ones  = ((val_q & TopMask) == TopMask);
  assign more      = (|rest_q[63:32]) && (nch_q != ChunkCntW'(MaxChunks));
  assign word      = narrow_q ? val_q[31:0] : rest_q[31:0];
  assign word_sum  = word + RoundAddW;
  assign val_msb   = high_one(val_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (accept) state_d = F_LOOP;
      F_LOOP:  state_d = (!narrow_q && !top_ones && more) ? F_NORM : F_FINAL;
      F_NORM:  state_d = F_LOOP;
      F_FINAL: if (!plan_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          val_q    <= in_data_i.load_value;
          rest_q   <= in_data_i.load_value;
          rd_q     <= in_data_i.dest_reg;
          narrow_q <= in_data_i.narrow_register;
          nch_q    <= '0;
        end
      end
      F_LOOP: begin
        // round the remainder and keep its low 12 bits as the next chunk
        if (!narrow_q && !top_ones && more) begin
          upper_q            <= round_sum[63:12];
          chunk_imm_q[nch_q] <= rest_q[11:0];
        end
      end
      F_NORM: begin
        // strip trailing zeros; they come back as part of the shift
        rest_q               <= {12'b0, shifted};
        chunk_shift_q[nch_q] <= lsb + ChunkBase;
        nch_q                <= nch_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign plan_push_o = (state_q == F_FINAL) && !plan_full_i;

  always_comb begin
    plan_o             = '0;
    plan_o.rd          = rd_q;
    plan_o.chunk_imm   = chunk_imm_q;
    plan_o.chunk_shift = chunk_shift_q;
    plan_o.tail_amt    = ~val_msb;
    if (!narrow_q && top_ones) begin
      plan_o.lui_imm = '0;
      plan_o.add_en  = 1'b1;
      plan_o.add_op  = OP_ADDI;
      plan_o.add_imm = val_q[11:0];
      plan_o.nchunks = '0;
      plan_o.tail_en = 1'b0;
    end else begin
      plan_o.lui_imm = word_sum[31:12];
      plan_o.add_en  = |word[11:0];
      plan_o.add_op  = narrow_q ? OP_ADDI : OP_ADDIW;
      plan_o.add_imm = word[11:0];
      plan_o.nchunks = narrow_q ? '0 : nch_q;
      // core tops out at bit 31: clear the sign extension afterwards
      plan_o.tail_en = !narrow_q && rest_q[31] && !val_q[63];
    end
  end

endmodule

### rtl/rlie_plan_fifo.sv
// ----------------------------------------------------------------------------
// rlie_plan_fifo: short queue of plan records between front and back
// Register array with wrap-around pointers and an occupancy count.
// ----------------------------------------------------------------------------
module rlie_plan_fifo import rlie_pkg::*; #(
  parameter int unsigned PlanDepth = PlanDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  plan_t data_i,
  input  logic  pop_i,
  output logic  empty_o,
  output plan_t data_o
);

  localparam int unsigned PtrW = (PlanDepth > 1) ? $clog2(PlanDepth) : 1;
  localparam int unsigned CntW = $clog2(PlanDepth + 1);

  plan_t            mem_q [PlanDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(PlanDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(PlanDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(PlanDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/rlie_back.sv
// ----------------------------------------------------------------------------
// rlie_back: walk a plan record and issue one instruction per unstalled cycle
// LUI, optional add, shift/add per chunk from the top chunk down, optional
// SLLI/SRLI pair. Results wait in an output register.
// ----------------------------------------------------------------------------
module rlie_back import rlie_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      plan_empty_i,
  output logic      plan_pop_o,
  input  plan_t     plan_i,
  output logic      out_empty_o,
  input  logic      out_pop_i,
  output out_item_t out_data_o
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_LUI,
    B_ADD,
    B_SLL,
    B_CADD,
    B_TSLL,
    B_TSRL
  } state_e;

  state_e               state_q, state_d;
  logic [1:0]           ci_q, ci_d;
  plan_t                plan_q;
  out_item_t            out_q;
  logic                 out_valid_q;

  state_e               aw_state, ac_state;
  logic [1:0]           aw_ci, ac_ci;
  logic                 emit;
  out_item_t            instr;

  assign plan_pop_o  = (state_q == B_IDLE) && !plan_empty_i;
  assign emit        = (state_q != B_IDLE) && (!out_valid_q || out_pop_i);
  assign out_empty_o = !out_valid_q;
  assign out_data_o  = out_q;

  // after the word: top chunk first, else the tail pair, else done
  always_comb begin
    aw_ci = ci_q;
    if (plan_q.nchunks != '0) begin
      aw_state = B_SLL;
      aw_ci    = 2'(plan_q.nchunks - 1'b1);
    end else if (plan_q.tail_en) begin
      aw_state = B_TSLL;
    end else begin
      aw_state = B_IDLE;
    end
  end

  // after a chunk: next lower chunk, else the tail pair, else done
  always_comb begin
    ac_ci = ci_q;
    if (ci_q != '0) begin
      ac_state = B_SLL;
      ac_ci    = ci_q - 1'b1;
    end else if (plan_q.tail_en) begin
      ac_state = B_TSLL;
    end else begin
      ac_state = B_IDLE;
    end
  end

  always_comb begin
    state_d = state_q;
    ci_d    = ci_q;
    case (state_q)
      B_IDLE: begin
        if (plan_pop_o) state_d = B_LUI;
      end
      B_LUI: begin
        if (plan_q.add_en) begin
          state_d = B_ADD;
        end else begin
          state_d = aw_state;
          ci_d    = aw_ci;
        end
      end
      B_ADD: begin
        state_d = aw_state;
        ci_d    = aw_ci;
      end
      B_SLL: begin
        if (plan_q.chunk_imm[ci_q] != '0) begin
          state_d = B_CADD;
        end else begin
          state_d = ac_state;
          ci_d    = ac_ci;
        end
      end
      B_CADD: begin
        state_d = ac_state;
        ci_d    = ac_ci;
      end
      B_TSLL:  state_d = B_TSRL;
      B_TSRL:  state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    instr.rd        = plan_q.rd;
    instr.rs1       = plan_q.rd;
    instr.opcode    = OP_SLLI;
    instr.immediate = '0;
    instr.last      = (state_d == B_IDLE);
    case (state_q)
      B_LUI: begin
        instr.opcode    = OP_LUI;
        instr.rs1       = '0;
        instr.immediate = plan_q.lui_imm;
      end
      B_ADD: begin
        instr.opcode    = plan_q.add_op;
        instr.immediate = {8'b0, plan_q.add_imm};
      end
      B_SLL: begin
        instr.opcode    = OP_SLLI;
        instr.immediate = {14'b0, plan_q.chunk_shift[ci_q]};
      end
      B_CADD: begin
        instr.opcode    = OP_ADDI;
        instr.immediate = {8'b0, plan_q.chunk_imm[ci_q]};
      end
      B_TSLL: begin
        instr.opcode    = OP_SLLI;
        instr.immediate = {14'b0, plan_q.tail_amt};
      end
      B_TSRL: begin
        instr.opcode    = OP_SRLI;
        instr.immediate = {14'b0, plan_q.tail_amt};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      ci_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // hold the sequencer while the output word is stalled
      if (state_q == B_IDLE || emit) begin
        state_q <= state_d;
        ci_q    <= ci_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (plan_pop_o) begin
      plan_q <= plan_i;
    end
    if (emit) begin
      out_q <= instr;
    end
  end

endmodule

### rtl/riscv_load_immediate_expander.sv
// ----------------------------------------------------------------------------
// riscv_load_immediate_expander: RV64 load-immediate instruction expander
// Turns a 64-bit constant into the LUI/ADDI(W)/SLLI/SRLI words that build it.
// ----------------------------------------------------------------------------
// Each word pushed in yields one to ten instruction words, the last one
// flagged. The front part peels k 12-bit chunks off a constant, rounding
// and then stripping trailing zeros for each (k is at most 3), then hands
// a plan record to a queue of PlanDepth entries; the back part loads a
// plan and then issues one instruction per cycle while the result queue is
// popped. The back part's single issue slot sets the throughput as long as
// the front part keeps ahead; full rises while the front part works on a
// word, so a new constant is taken only after the previous plan is pushed.
module riscv_load_immediate_expander import rlie_pkg::*; #(
  parameter int unsigned PlanDepth = PlanDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data_o
);

  plan_t front_plan, back_plan;
  logic  plan_push, plan_full, plan_pop, plan_empty;

  rlie_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_push_i   (push),
    .in_full_o   (full),
    .in_data_i   (in_data_i),
    .plan_push_o (plan_push),
    .plan_full_i (plan_full),
    .plan_o      (front_plan)
  );

  rlie_plan_fifo #(
    .PlanDepth (PlanDepth)
  ) u_plan_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (plan_push),
    .full_o  (plan_full),
    .data_i  (front_plan),
    .pop_i   (plan_pop),
    .empty_o (plan_empty),
    .data_o  (back_plan)
  );

  rlie_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_empty_i (plan_empty),
    .plan_pop_o   (plan_pop),
    .plan_i       (back_plan),
    .out_empty_o  (empty),
    .out_pop_i    (pop),
    .out_data_o   (out_data_o)
  );

endmodule

### rtl/rlie_checker.sv
// ----------------------------------------------------------------------------
// rlie_port_props: port-level checks of the load-immediate expander
// Watches the result queue for stall behavior and sequence structure.
// ----------------------------------------------------------------------------
module rlie_port_props import rlie_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data_o
);

  logic pop_done;
  logic pop_mid;

  assign pop_done = pop && !empty && out_data_o.last;
  assign pop_mid  = pop && !empty && !out_data_o.last;

  // a waiting word stays put until popped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result word changed while stalled");

  a_lui_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.opcode == OP_LUI) |-> (out_data_o.rs1 == '0))
    else $error("LUI with nonzero source register");

  a_seq_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(pop_done) && !empty) |-> (out_data_o.opcode == OP_LUI))
    else $error("sequence does not open with LUI");

  a_seq_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(pop_mid) && !empty) |->
      (out_data_o.rd == $past(out_data_o.rd) && out_data_o.opcode != OP_LUI &&
       out_data_o.rs1 == out_data_o.rd))
    else $error("instruction inside a sequence changed register or restarted");

endmodule

bind riscv_load_immediate_expander rlie_port_props u_checker (.*);
